>>> rtl/core/u8sf_pkg.sv
// ----------------------------------------------------------------------------
// u8sf_pkg
// Shared constants and decode helpers for the UTF-8 sequence filter.
// ----------------------------------------------------------------------------
package u8sf_pkg;

  localparam int unsigned MaxSeq    = 4;
  localparam int unsigned PendDepth = MaxSeq - 1;
  localparam int unsigned LenW      = $clog2(MaxSeq + 1);
  localparam int unsigned CapW      = 16;
  localparam int unsigned AddrW     = 2;

  localparam logic [AddrW-1:0] CapAddr  = '0;
  localparam logic [CapW-1:0]  CapReset = 16'd256;

  localparam logic [7:0] LeadAsciiLim = 8'h80;
  localparam logic [7:0] Mask2        = 8'hE0;
  localparam logic [7:0] Lead2        = 8'hC0;
  localparam logic [7:0] Mask3        = 8'hF0;
  localparam logic [7:0] Lead3        = 8'hE0;
  localparam logic [7:0] Mask4        = 8'hF8;
  localparam logic [7:0] Lead4        = 8'hF0;
  localparam logic [7:0] ContMask     = 8'hC0;
  localparam logic [7:0] ContCode     = 8'h80;

  // Sequence length announced by a lead byte, zero for a byte that leads nothing
  function automatic logic [LenW-1:0] lead_length(input logic [7:0] c);
    logic [LenW-1:0] len;
    len = '0;
    if (c < LeadAsciiLim) begin
      len = LenW'(1);
    end else if ((c & Mask2) == Lead2) begin
      len = LenW'(2);
    end else if ((c & Mask3) == Lead3) begin
      len = LenW'(3);
    end else if ((c & Mask4) == Lead4) begin
      len = LenW'(4);
    end
    return len;
  endfunction

  function automatic logic is_continuation(input logic [7:0] c);
    return (c & ContMask) == ContCode;
  endfunction

endpackage

>>> rtl/core/utf8_sequence_filter.sv
// An input byte is held in the input register, then loads the result register.
// Throughput: one input byte and one result per cycle, each unless stalled;
// results leave a four-entry result register, which takes a new group once
// its last entry goes. The final byte of a four-byte sequence releases a burst
// of four results. Reset (rst_ni low, asynchronous) closes any open sequence,
// clears the written count, empties both stages and sets capacity to 256.
// ----------------------------------------------------------------------------
// utf8_sequence_filter
// Drops malformed UTF-8 sequences from a zero-terminated byte stream and
// emits well-formed ones while they fit in the output buffer.
// ----------------------------------------------------------------------------
module utf8_sequence_filter
  import u8sf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input stream
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  // result stream
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             end_of_text_o,
  output logic             last_of_run_o
);

  // configuration register
  logic [CapW-1:0] cap_q;
  logic            cap_sel;

  assign pready  = 1'b1;
  assign cap_sel = (paddr == CapAddr);
  assign prdata  = cap_sel ? 32'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      cap_q <= pwdata[CapW-1:0];
    end
  end

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // sequence state
  logic [LenW-1:0] seq_len_q, seq_len_d;
  logic [LenW-1:0] bc_q, bc_d;
  logic            sok_q, sok_d;
  logic [CapW-1:0] wc_q, wc_d;
  logic [7:0]      pend_q [PendDepth];

  // result group
  logic [7:0]      grp_q [MaxSeq];
  logic [7:0]      grp_d [MaxSeq];
  logic [LenW-1:0] grp_cnt_q, grp_cnt_d;
  logic            eot_q, eot_d;

  logic            pend_wr;
  logic [1:0]      pend_idx;
  logic [LenW-1:0] n_res;
  logic            res_eot;
  logic            grp_free, consume, load, drain;

  logic [LenW-1:0] eff_len, eff_bc, lead;
  logic            eff_ok, go;

  always_comb begin
    seq_len_d = seq_len_q;
    bc_d      = bc_q;
    sok_d     = sok_q;
    wc_d      = wc_q;
    pend_wr   = 1'b0;
    pend_idx  = bc_q[1:0];
    n_res     = '0;
    res_eot   = 1'b0;
    eff_len   = seq_len_q;
    eff_bc    = bc_q;
    eff_ok    = sok_q && is_continuation(in_byte_q);
    lead      = lead_length(in_byte_q);
    go        = 1'b1;

    if (in_byte_q == 8'd0) begin
      // end of string: drop any open sequence, terminate when there is room
      seq_len_d = '0;
      bc_d      = '0;
      sok_d     = 1'b1;
      wc_d      = '0;
      if (cap_q != '0) begin
        n_res   = LenW'(1);
        res_eot = 1'b1;
      end
    end else begin
      if (seq_len_q == '0) begin
        if (cap_q == '0 || ({1'b0, wc_q} + 17'd1) >= {1'b0, cap_q} || lead == '0) begin
          go = 1'b0;
        end
        eff_len = lead;
        eff_bc  = '0;
        eff_ok  = 1'b1;
      end
      if (go) begin
        if ((eff_bc + LenW'(1)) < eff_len) begin
          pend_wr   = 1'b1;
          pend_idx  = eff_bc[1:0];
          seq_len_d = eff_len;
          bc_d      = eff_bc + LenW'(1);
          sok_d     = eff_ok;
        end else begin
          seq_len_d = '0;
          bc_d      = '0;
          sok_d     = 1'b1;
          if (eff_ok && ({1'b0, wc_q} + 17'(eff_len)) < {1'b0, cap_q}) begin
            n_res = eff_len;
            wc_d  = wc_q + CapW'(eff_len);
          end
        end
      end
    end
  end

  // a byte that causes no result never waits on the output side
  assign drain      = out_valid_o && !out_stall_i;
  assign grp_free   = (grp_cnt_q == '0) || (grp_cnt_q == LenW'(1) && !out_stall_i);
  assign consume    = in_vld_q && ((n_res == '0) || grp_free);
  assign load       = consume && (n_res != '0);
  assign in_stall_o = in_vld_q && !consume;

  always_comb begin
    grp_cnt_d = grp_cnt_q;
    eot_d     = eot_q;
    for (int k = 0; k < MaxSeq; k++) begin
      grp_d[k] = grp_q[k];
    end
    if (load) begin
      grp_cnt_d = n_res;
      eot_d     = res_eot;
      for (int k = 0; k < PendDepth; k++) begin
        if (LenW'(k + 1) == n_res) begin
          grp_d[k] = in_byte_q;
        end else begin
          grp_d[k] = pend_q[k];
        end
      end
      grp_d[MaxSeq-1] = in_byte_q;
    end else if (drain) begin
      grp_cnt_d = grp_cnt_q - LenW'(1);
      // advance the next entry to the head
      for (int k = 0; k < MaxSeq - 1; k++) begin
        grp_d[k] = grp_q[k + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      seq_len_q <= '0;
      bc_q      <= '0;
      sok_q     <= 1'b1;
      wc_q      <= '0;
      grp_cnt_q <= '0;
      eot_q     <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (consume) begin
        seq_len_q <= seq_len_d;
        bc_q      <= bc_d;
        sok_q     <= sok_d;
        wc_q      <= wc_d;
      end
      grp_cnt_q <= grp_cnt_d;
      eot_q     <= eot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= data_byte_i;
    end
    if (consume && pend_wr) begin
      pend_q[pend_idx] <= in_byte_q;
    end
    for (int k = 0; k < MaxSeq; k++) begin
      grp_q[k] <= grp_d[k];
    end
  end

  assign out_valid_o   = grp_cnt_q != '0;
  assign out_byte_o    = grp_q[0];
  assign last_of_run_o = grp_cnt_q == LenW'(1);
  assign end_of_text_o = eot_q && (grp_cnt_q == LenW'(1));

`ifndef ASSERT_OFF
  a_eot_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_text_o |-> last_of_run_o && out_byte_o == 8'd0)
    else $error("terminator not a lone zero result");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  a_collect_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_len_q != '0 |-> bc_q < seq_len_q)
    else $error("collected count reached the sequence length");

  a_group_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> grp_cnt_q != '0 && grp_cnt_q <= LenW'(MaxSeq))
    else $error("result group count out of range after load");
`endif

endmodule
